// File: rtl/fati_pkg.sv
package fati_pkg;

  localparam int AXIS_COUNT = 5;
  localparam int WORD_W = 32;
  localparam int CORNERS = 32;

  typedef enum logic [1:0] {
    OP_POINT = 2'd0,
    OP_ENTRY = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [2:0] CFG_LEN_ZERO  = 3'd0;
  localparam logic [2:0] CFG_LEN_ONE   = 3'd1;
  localparam logic [2:0] CFG_LEN_TWO   = 3'd2;
  localparam logic [2:0] CFG_LEN_THREE = 3'd3;
  localparam logic [2:0] CFG_LEN_FOUR  = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_ADDR,
    ST_FETCH,
    ST_FETCH_WAIT,
    ST_BLEND_MUL,
    ST_BLEND_ADD,
    ST_OUT
  } state_t;

  // divider handshake
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

// File: rtl/five_axis_table_interpolator.sv
// a query's duration is set by the serial breakpoint search, the bit-serial fraction
//   divider, five address steps per corner on the single table port and two blend
//   multipliers, one per result, shared by all pairs
// throughput: one item at a time; s_tready is low from an accepted query until its result
//   is loaded into the output register; the load waits while an older result is not yet taken
// reset: rst is synchronous active high; axis lengths reset to 8; stores are not cleared
module five_axis_table_interpolator #(
  parameter int MAX_AXIS_POINTS = 8,
  parameter int TABLE_ADDR_BITS = 15,
  parameter int FRAC_BITS       = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // operation[1:0]
  input  logic [1:0]   s_tuser,
  // axis_number[2:0], write_index[17:3], write_value_first[49:18],
  // write_value_second[81:50], coord_zero..coord_four[113:82]..[241:210], pad to 248
  input  logic [247:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // result_first[31:0], result_second[63:32]
  output logic [63:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [3:0]   cfg_data
);

  localparam int W     = fati_pkg::WORD_W;
  localparam int NA    = fati_pkg::AXIS_COUNT;
  localparam int PT_W  = $clog2(MAX_AXIS_POINTS);
  localparam int LEN_W = $clog2(MAX_AXIS_POINTS + 1);
  localparam int F_W   = FRAC_BITS + 1;
  localparam int NUM_W = W + 1 + FRAC_BITS;
  localparam int DEN_W = W + 1;
  localparam int PT_DEPTH = NA * MAX_AXIS_POINTS;
  localparam int PA_W  = $clog2(PT_DEPTH);
  localparam int TA_W  = TABLE_ADDR_BITS;
  localparam int AC_W  = TA_W + 8;

  // input fields
  logic [1:0]  in_op;
  logic [2:0]  in_axis;
  logic [14:0] in_widx;
  logic [W-1:0] in_v1, in_v2;
  assign in_op   = s_tuser;
  assign in_axis = s_tdata[2:0];
  assign in_widx = s_tdata[17:3];
  assign in_v1   = s_tdata[49:18];
  assign in_v2   = s_tdata[81:50];

  // config registers
  logic [3:0] len_reg [NA];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NA; i++) len_reg[i] <= 4'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fati_pkg::CFG_LEN_ZERO:  len_reg[0] <= cfg_data;
        fati_pkg::CFG_LEN_ONE:   len_reg[1] <= cfg_data;
        fati_pkg::CFG_LEN_TWO:   len_reg[2] <= cfg_data;
        fati_pkg::CFG_LEN_THREE: len_reg[3] <= cfg_data;
        fati_pkg::CFG_LEN_FOUR:  len_reg[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  fati_pkg::state_t state, state_next;
  logic accept;
  logic out_free;
  assign s_tready = (state == fati_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // query registers
  logic signed [W-1:0] coord [NA];
  logic [2:0]          ax;
  logic [PT_W:0]       k;
  logic                hi_chk;
  logic [LEN_W-1:0]    alen;
  logic [PT_W-1:0]     seg [NA];
  logic [F_W-1:0]      frac [NA];
  logic [LEN_W-1:0]    lens [NA];
  logic signed [W-1:0] plo, pcur;
  logic signed [W-1:0] x;

  // breakpoint memory
  logic [W-1:0] pmem [0:PT_DEPTH-1];
  logic [PA_W-1:0] prd_addr;
  logic [W-1:0] prd;
  logic pwe;
  assign pwe = accept && in_op == fati_pkg::OP_POINT && in_axis < 3'(NA)
               && in_widx < 15'(MAX_AXIS_POINTS);
  always_ff @(posedge clk) begin
    if (pwe) pmem[PA_W'(in_axis * MAX_AXIS_POINTS + in_widx[PT_W-1:0])] <= in_v1;
    prd <= pmem[prd_addr];
  end
  assign prd_addr = PA_W'(ax * MAX_AXIS_POINTS + k[PT_W-1:0]);

  // clamp length for the current axis
  logic [LEN_W-1:0] alen_c;
  always_comb begin
    if (len_reg[ax] < 4'd2) alen_c = LEN_W'(2);
    else if (32'(len_reg[ax]) > MAX_AXIS_POINTS) alen_c = LEN_W'(MAX_AXIS_POINTS);
    else alen_c = LEN_W'(len_reg[ax]);
  end

  assign x = coord[ax];

  // divider
  logic div_start;
  fati_pkg::div_ctl_t dctl;
  logic [F_W-1:0] dquot;
  logic [NUM_W-1:0] dnum;
  logic [DEN_W-1:0] dden;
  logic signed [W:0] gap, off;
  assign gap  = {pcur[W-1], pcur} - {plo[W-1], plo};
  assign off  = {x[W-1], x} - {plo[W-1], plo};
  assign dnum = {off, {FRAC_BITS{1'b0}}};
  assign dden = gap;
  fati_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(F_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(dnum), .den(dden),
    .ctl(dctl), .quot(dquot)
  );

  // table memory
  logic [TA_W-1:0] taddr;
  logic [63:0]     trd;
  logic            twe;
  logic [TA_W-1:0] caddr;
  assign twe = accept && in_op == fati_pkg::OP_ENTRY && 32'(in_widx) < (1 << TA_W);
  assign taddr = (state == fati_pkg::ST_IDLE) ? TA_W'(in_widx) : caddr;
  fati_table_ram #(.ADDR_W(TA_W), .DATA_W(64)) u_tab (
    .clk(clk), .we(twe), .addr(taddr), .wdata({in_v2, in_v1}), .rdata(trd)
  );

  // corner sweep and blend stack
  logic [5:0] corner;
  logic [AC_W-1:0] acc;
  logic signed [W-1:0] v1 [32];
  logic signed [W-1:0] v2 [32];
  logic [4:0] bi;
  logic [2:0] level;
  logic [4:0] bcnt;
  logic signed [W+F_W+1:0] p1, p2;
  logic signed [W-1:0] a1, a2;

  // corner address, one axis digit per cycle
  logic [AC_W-1:0] acc_step;
  logic [4:0] cc;
  assign cc = corner[4:0];
  always_comb begin
    acc_step = AC_W'(acc * lens[ax]) + AC_W'(seg[ax]) + AC_W'(cc[3'd4 - ax]);
  end

  // blend product: (b-a)*f
  logic signed [W:0] bdiff1, bdiff2;
  logic [F_W-1:0] fcur;
  assign fcur   = frac[3'd4 - level];
  assign bdiff1 = {v1[{bi[3:0],1'b1}][W-1], v1[{bi[3:0],1'b1}]}
                  - {v1[{bi[3:0],1'b0}][W-1], v1[{bi[3:0],1'b0}]};
  assign bdiff2 = {v2[{bi[3:0],1'b1}][W-1], v2[{bi[3:0],1'b1}]}
                  - {v2[{bi[3:0],1'b0}][W-1], v2[{bi[3:0],1'b0}]};

  function automatic logic signed [W-1:0] shr_floor(input logic signed [W+F_W+1:0] p,
                                                     input logic signed [W-1:0] a);
    logic signed [W+F_W+1:0] q;
    q = p >>> FRAC_BITS;
    return W'(a + W'(q));
  endfunction

  // search decisions: first breakpoint, then last breakpoint, then scan upward
  logic ax_done, ax_last, go_div;
  logic [PT_W:0] last_k;
  assign last_k  = (PT_W+1)'(alen - 1'b1);
  assign ax_last = (ax == 3'(NA-1));
  always_comb begin
    ax_done = 1'b0;
    go_div  = 1'b0;
    if (state == fati_pkg::ST_SRCH_CMP) begin
      if (k == '0) begin
        ax_done = (x <= $signed(prd));
      end else if (hi_chk) begin
        ax_done = (x >= $signed(prd));
      end else if (k == last_k || $signed(prd) >= x) begin
        go_div = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      fati_pkg::ST_IDLE:
        if (accept && in_op == fati_pkg::OP_QUERY) state_next = fati_pkg::ST_SRCH_RD;
      fati_pkg::ST_SRCH_RD: state_next = fati_pkg::ST_SRCH_CMP;
      fati_pkg::ST_SRCH_CMP: begin
        if (ax_done) state_next = ax_last ? fati_pkg::ST_ADDR : fati_pkg::ST_SRCH_RD;
        else if (go_div) state_next = fati_pkg::ST_DIV_START;
        else state_next = fati_pkg::ST_SRCH_RD;
      end
      fati_pkg::ST_DIV_START: begin
        div_start  = 1'b1;
        state_next = fati_pkg::ST_DIV_WAIT;
      end
      fati_pkg::ST_DIV_WAIT:
        if (dctl.done) state_next = (ax == 3'(NA-1)) ? fati_pkg::ST_ADDR : fati_pkg::ST_SRCH_RD;
      fati_pkg::ST_ADDR:
        if (ax == 3'(NA-1)) state_next = fati_pkg::ST_FETCH;
      fati_pkg::ST_FETCH: state_next = fati_pkg::ST_FETCH_WAIT;
      fati_pkg::ST_FETCH_WAIT:
        state_next = (corner == 6'd31) ? fati_pkg::ST_BLEND_MUL : fati_pkg::ST_ADDR;
      fati_pkg::ST_BLEND_MUL: state_next = fati_pkg::ST_BLEND_ADD;
      fati_pkg::ST_BLEND_ADD:
        if (level == 3'd4 && bi == 5'd0) state_next = fati_pkg::ST_OUT;
        else state_next = fati_pkg::ST_BLEND_MUL;
      fati_pkg::ST_OUT:
        if (out_free) state_next = fati_pkg::ST_IDLE;
      default: state_next = fati_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= fati_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (state == fati_pkg::ST_OUT && out_free) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  // datapath sequencing
  always_ff @(posedge clk) begin
    if (!rst) begin
      unique case (state)
        fati_pkg::ST_IDLE: if (accept && in_op == fati_pkg::OP_QUERY) begin
          for (int i = 0; i < NA; i++) coord[i] <= s_tdata[82 + 32*i +: 32];
          ax     <= '0;
          k      <= '0;
          hi_chk <= 1'b0;
        end
        fati_pkg::ST_SRCH_RD: if (k == '0) alen <= alen_c;
        fati_pkg::ST_SRCH_CMP: begin
          lens[ax] <= alen;
          if (ax_done) begin
            if (hi_chk) begin
              seg[ax]  <= PT_W'(alen - LEN_W'(2));
              frac[ax] <= F_W'(1) << FRAC_BITS;
            end else begin
              seg[ax]  <= '0;
              frac[ax] <= '0;
            end
            k      <= '0;
            hi_chk <= 1'b0;
            if (ax_last) begin
              ax     <= '0;
              corner <= '0;
              acc    <= '0;
            end else begin
              ax <= ax + 3'd1;
            end
          end else if (go_div) begin
            pcur    <= $signed(prd);
            seg[ax] <= PT_W'(k - 1'b1);
          end else if (k == '0) begin
            plo    <= $signed(prd);
            k      <= last_k;
            hi_chk <= 1'b1;
          end else if (hi_chk) begin
            k      <= (PT_W+1)'(1);
            hi_chk <= 1'b0;
          end else begin
            plo <= $signed(prd);
            k   <= k + 1'b1;
          end
        end
        fati_pkg::ST_DIV_WAIT: if (dctl.done) begin
          frac[ax] <= (gap <= 0 || off < 0) ? '0 : dquot;
          k <= '0;
          if (ax_last) begin
            ax <= '0;
            corner <= '0;
            acc <= '0;
          end else begin
            ax <= ax + 3'd1;
          end
        end
        fati_pkg::ST_ADDR: begin
          acc <= acc_step;
          if (ax_last) begin
            caddr <= TA_W'(acc_step);
            ax <= '0;
          end else begin
            ax <= ax + 3'd1;
          end
        end
        fati_pkg::ST_FETCH_WAIT: begin
          v1[corner[4:0]] <= trd[31:0];
          v2[corner[4:0]] <= trd[63:32];
          corner <= corner + 6'd1;
          acc    <= '0;
          if (corner == 6'd31) begin
            level <= '0;
            bi    <= '0;
            bcnt  <= 5'd15;
          end
        end
        fati_pkg::ST_BLEND_MUL: begin
          p1 <= bdiff1 * $signed({1'b0, fcur});
          p2 <= bdiff2 * $signed({1'b0, fcur});
          a1 <= v1[{bi[3:0],1'b0}];
          a2 <= v2[{bi[3:0],1'b0}];
        end
        fati_pkg::ST_BLEND_ADD: begin
          v1[bi] <= shr_floor(p1, a1);
          v2[bi] <= shr_floor(p2, a2);
          if (bi == bcnt) begin
            bi    <= '0;
            level <= level + 3'd1;
            bcnt  <= bcnt >> 1;
          end else begin
            bi <= bi + 5'd1;
          end
        end
        fati_pkg::ST_OUT: if (out_free) begin
          m_tdata <= {v2[0], v1[0]};
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/fati_divider.sv
// restoring divider: one quotient bit per cycle
module fati_divider #(
  parameter int NUM_W = 56,
  parameter int DEN_W = 33,
  parameter int Q_W   = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output fati_pkg::div_ctl_t ctl,
  output logic [Q_W-1:0]   quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] nreg;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] dreg;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  // shift in next numerator bit, trial subtract
  always_comb begin
    trial = {rem[DEN_W-1:0], nreg[NUM_W-1]};
    diff  = trial - {1'b0, dreg};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
        nreg <= num;
        dreg <= den;
        rem  <= '0;
        quot <= '0;
      end else if (busy) begin
        nreg <= {nreg[NUM_W-2:0], 1'b0};
        if (!diff[DEN_W]) begin
          rem  <= diff;
          quot <= {quot[Q_W-2:0], 1'b1};
        end else begin
          rem  <= trial;
          quot <= {quot[Q_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign ctl.start = start;
  assign ctl.busy  = busy;
  assign ctl.done  = done;

endmodule

// File: rtl/fati_table_ram.sv
// single-port table memory with registered read
module fati_table_ram #(
  parameter int ADDR_W = 15,
  parameter int DATA_W = 64
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [0:(1<<ADDR_W)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PTS = 8;
  localparam int FRAC_W = 16;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int ITEM_TARGET = 600;

  typedef struct {
    fati_pkg::op_t op;
    logic [2:0] axis;
    logic [14:0] widx;
    logic [31:0] val_a;
    logic [31:0] val_b;
    logic [31:0] coord[fati_pkg::AXIS_COUNT];
  } item_t;

  // predictor of the interpolator with its own copy of lengths and stores
  class interp_scoreboard;
    logic [3:0] len_reg[fati_pkg::AXIS_COUNT];
    logic [31:0] points[fati_pkg::AXIS_COUNT*MAX_PTS];
    logic [63:0] entries[int];
    logic [63:0] pending_results[$];
    int errors;

    function new();
      foreach (len_reg[a]) len_reg[a] = 4'd8;
      errors = 0;
    endfunction

    function int eff_len(int a);
      int n;
      n = int'(len_reg[a]);
      if (n < 2) n = 2;
      if (n > MAX_PTS) n = MAX_PTS;
      return n;
    endfunction

    function longint point_val(int a, int k);
      return longint'($signed(points[a*MAX_PTS+k]));
    endfunction

    // segment search and fraction on one axis
    function void locate(int a, longint x, output int seg, output longint frac);
      int n, k;
      longint lo, hi;
      n = eff_len(a);
      if (x <= point_val(a, 0)) begin
        seg = 0;
        frac = 0;
      end else if (x >= point_val(a, n-1)) begin
        seg = n - 2;
        frac = longint'(1) << FRAC_W;
      end else begin
        k = 1;
        while (k < n-1 && point_val(a, k) < x) k++;
        seg = k - 1;
        lo = point_val(a, k-1);
        hi = point_val(a, k);
        if (hi - lo <= 0 || x - lo < 0) frac = 0;
        else frac = ((x - lo) << FRAC_W) / (hi - lo);
      end
    endfunction

    function void corners(item_t it, output int addr[32],
                          output longint fr[fati_pkg::AXIS_COUNT]);
      int seg[fati_pkg::AXIS_COUNT];
      int acc;
      for (int a = 0; a < fati_pkg::AXIS_COUNT; a++)
        locate(a, longint'($signed(it.coord[a])), seg[a], fr[a]);
      for (int c = 0; c < 32; c++) begin
        acc = 0;
        for (int a = 0; a < fati_pkg::AXIS_COUNT; a++)
          acc = acc * eff_len(a) + seg[a] + ((c >> (4-a)) & 1);
        addr[c] = acc & 32'h7fff;
      end
    endfunction

    function longint blend(longint lo_v, longint hi_v, longint f);
      longint p;
      p = (hi_v - lo_v) * f;
      return lo_v + (p >>> FRAC_W);
    endfunction

    function void note_input(item_t it);
      int addr[32];
      longint fr[fati_pkg::AXIS_COUNT];
      longint va[32], vb[32];
      int cnt;
      case (it.op)
        fati_pkg::OP_POINT: begin
          if (it.axis < fati_pkg::AXIS_COUNT && it.widx < MAX_PTS)
            points[it.axis*MAX_PTS + it.widx] = it.val_a;
        end
        fati_pkg::OP_ENTRY: entries[it.widx] = {it.val_b, it.val_a};
        fati_pkg::OP_QUERY: begin
          corners(it, addr, fr);
          for (int c = 0; c < 32; c++) begin
            va[c] = longint'($signed(entries[addr[c]][31:0]));
            vb[c] = longint'($signed(entries[addr[c]][63:32]));
          end
          cnt = 32;
          for (int a = fati_pkg::AXIS_COUNT-1; a >= 0; a--) begin
            cnt = cnt / 2;
            for (int c = 0; c < cnt; c++) begin
              va[c] = blend(va[2*c], va[2*c+1], fr[a]);
              vb[c] = blend(vb[2*c], vb[2*c+1], fr[a]);
            end
          end
          pending_results.push_back({vb[0][31:0], va[0][31:0]});
        end
        default: ;
      endcase
    endfunction

    function void check(logic [63:0] got);
      logic [63:0] want;
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: %h", got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got[31:0] !== want[31:0]) begin
        $error("result_first expected %h actual %h", want[31:0], got[31:0]);
        errors++;
      end
      if (got[63:32] !== want[63:32]) begin
        $error("result_second expected %h actual %h", want[63:32], got[63:32]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [1:0] s_tuser = '0;
  logic [247:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = fati_pkg::CFG_LEN_ZERO;
  logic [3:0] cfg_data = '0;

  interp_scoreboard sb = new();
  int items_sent = 0;
  bit calm = 1'b0;
  longint cycles = 0;

  five_axis_table_interpolator DUT (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // mostly short gaps, a few long ones, none in calm phases
  function int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function logic [247:0] pack_data(item_t it);
    return {6'd0, it.coord[4], it.coord[3], it.coord[2], it.coord[1], it.coord[0],
            it.val_b, it.val_a, it.widx, it.axis};
  endfunction

  function item_t blank_item(fati_pkg::op_t op);
    item_t it;
    it.op = op;
    it.axis = 3'($urandom);
    it.widx = 15'($urandom);
    it.val_a = $urandom;
    it.val_b = $urandom;
    foreach (it.coord[a]) it.coord[a] = $urandom;
    return it;
  endfunction

  // one input transfer
  task send_item(item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.op;
    s_tdata <= pack_data(it);
    do @(posedge clk); while (!s_tready);
    sb.note_input(it);
    if (it.op != fati_pkg::OP_NONE) items_sent++;
  endtask

  task drain();
    s_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task write_lengths(logic [3:0] l[fati_pkg::AXIS_COUNT]);
    logic [2:0] idx[fati_pkg::AXIS_COUNT];
    idx = '{fati_pkg::CFG_LEN_ZERO, fati_pkg::CFG_LEN_ONE, fati_pkg::CFG_LEN_TWO,
            fati_pkg::CFG_LEN_THREE, fati_pkg::CFG_LEN_FOUR};
    for (int a = 0; a < fati_pkg::AXIS_COUNT; a++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[a];
      cfg_data <= l[a];
      @(posedge clk);
      sb.len_reg[a] = l[a];
    end
    cfg_we <= 1'b0;
  endtask

  task put_point(int a, int k, logic [31:0] v);
    item_t it;
    it = blank_item(fati_pkg::OP_POINT);
    it.axis = 3'(a);
    it.widx = 15'(k);
    it.val_a = v;
    send_item(it);
  endtask

  // breakpoints: mostly rising with random steps, sometimes flat or shuffled
  task load_axes(bit edges);
    longint v;
    int mode;
    for (int a = 0; a < fati_pkg::AXIS_COUNT; a++) begin
      mode = $urandom_range(0, 9);
      v = longint'($signed(32'($urandom))) >>> $urandom_range(0, 12);
      for (int k = 0; k < sb.eff_len(a); k++) begin
        if (edges && k == 0) v = -longint'(64'h80000000);
        else if (edges && k == sb.eff_len(a)-1) v = longint'(64'h7fffffff);
        else if (mode == 0) v = longint'($signed(32'($urandom)));
        else if (k > 0) v = v + (mode == 1 ? 0 : longint'($urandom_range(0, 1 << (mode*3))));
        if (v > 64'sh7fffffff) v = 64'sh7fffffff;
        put_point(a, k, v[31:0]);
      end
    end
  endtask

  function logic [31:0] pick_coord(int a);
    longint p0, pl, x;
    int n;
    n = sb.eff_len(a);
    p0 = sb.point_val(a, 0);
    pl = sb.point_val(a, n-1);
    case ($urandom_range(0, 9))
      0: x = -longint'(64'h80000000);
      1: x = 64'sh7fffffff;
      2: x = p0 - $urandom_range(0, 5000);
      3: x = pl + $urandom_range(0, 5000);
      4: x = sb.point_val(a, $urandom_range(0, n-1));
      5: x = longint'($signed(32'($urandom)));
      default: x = (pl > p0) ? p0 + longint'({$urandom, $urandom} % (pl - p0 + 1)) : p0;
    endcase
    if (x < -longint'(64'h80000000)) x = -longint'(64'h80000000);
    if (x > 64'sh7fffffff) x = 64'sh7fffffff;
    return x[31:0];
  endfunction

  // fills unwritten corners, then sends the query itself
  task run_query(item_t q, bit edges);
    int addr[32];
    longint fr[fati_pkg::AXIS_COUNT];
    item_t w;
    sb.corners(q, addr, fr);
    for (int c = 0; c < 32; c++) begin
      if (!sb.entries.exists(addr[c])) begin
        w = blank_item(fati_pkg::OP_ENTRY);
        w.widx = 15'(addr[c]);
        if (edges) begin
          w.val_a = c[0] ? 32'h7fffffff : 32'h80000000;
          w.val_b = c[1] ? 32'h80000000 : 32'h7fffffff;
        end
        send_item(w);
      end
    end
    send_item(q);
  endtask

  // writes that the block drops, no-op items, plus harmless overwrites
  task send_noise();
    item_t it;
    case ($urandom_range(0, 4))
      0: begin
        it = blank_item(fati_pkg::OP_POINT);
        it.axis = 3'($urandom_range(5, 7));
      end
      1: begin
        it = blank_item(fati_pkg::OP_POINT);
        it.axis = 3'($urandom_range(0, 4));
        it.widx = 15'($urandom_range(MAX_PTS, 32767));
      end
      2: it = blank_item(fati_pkg::OP_NONE);
      3: begin
        it = blank_item(fati_pkg::OP_POINT);
        it.axis = 3'($urandom_range(0, 4));
        it.widx = 15'($urandom_range(0, MAX_PTS-1));
      end
      default: it = blank_item(fati_pkg::OP_ENTRY);
    endcase
    send_item(it);
  endtask

  // output side backpressure
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        m_tready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  // result checking
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check(m_tdata);
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // stimulus phases
  initial begin
    logic [3:0] lens[fati_pkg::AXIS_COUNT];
    item_t q;
    int phase, nq;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      foreach (lens[a]) begin
        case (phase)
          0: lens[a] = 4'd2;
          1: lens[a] = 4'd8;
          2: lens[a] = (a % 2) ? 4'd15 : 4'(a / 2);
          default: lens[a] = ($urandom_range(0, 3) == 0) ? 4'($urandom) :
                             4'($urandom_range(2, 4));
        endcase
      end
      calm = (phase % 4 == 3);
      write_lengths(lens);
      load_axes(phase == 0);
      nq = (phase == 0) ? 6 : $urandom_range(4, 16);
      for (int i = 0; i < nq; i++) begin
        q = blank_item(fati_pkg::OP_QUERY);
        foreach (q.coord[a]) begin
          if (phase == 0)
            q.coord[a] = (i == 0) ? 32'h80000000 : (i == 1) ? 32'h7fffffff : pick_coord(a);
          else
            q.coord[a] = pick_coord(a);
        end
        if ($urandom_range(0, 5) == 0 || (phase == 0 && i < 4)) send_noise();
        run_query(q, phase == 0);
      end
      drain();
      phase++;
    end
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
